@@ rtl/tmrle_pkg.sv @@
// Tilemap run-length encoder: shared types, constants and helpers.
// Used by every module of the encoder; depends on nothing else.
`timescale 1ns / 1ps

package tmrle_pkg;

  // Layer geometry
  localparam int TILEMAP_ENTRIES = 1024;
  localparam int WORD_W          = 16;
  localparam int START_W         = 12;
  localparam int LEN_W           = 13;
  localparam int IDX_W           = 14;   // start + length without overflow

  // Result bundle: two runs of three words each plus the terminator
  localparam int MAX_RESULTS = 7;
  localparam int CNT_W       = 3;
  localparam int POS_W       = 3;

  // Fixed words
  localparam logic [WORD_W-1:0] FIXSRC_FLAG = 16'h4000;
  localparam logic [WORD_W-1:0] TERM_BYTE   = 16'h0080;

  // Configuration register indexes
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] REG_DEST_BASE   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_APPEND_TERM = 1'd1;

  // Results caused by one request, handed from tracker to serializer
  typedef struct packed {
    logic                                valid;
    logic [CNT_W-1:0]                    cnt;
    logic                                term;
    logic [MAX_RESULTS-1:0][WORD_W-1:0]  words;
  } bundle_t;

  // Length word: (len-1)*2, bit 14 set when the run is longer than one
  function automatic logic [WORD_W-1:0] len_word(input logic [LEN_W-1:0] len);
    logic [WORD_W-1:0] m1;
    logic [WORD_W-1:0] w;
    m1 = {{(WORD_W-LEN_W){1'b0}}, len} - 16'd1;
    w  = {m1[WORD_W-2:0], 1'b0};
    if (len > 13'd1) begin
      w = w | FIXSRC_FLAG;
    end
    return w;
  endfunction

endpackage

@@ rtl/tmrle_tracker.sv @@
// Run tracker: holds the open run and the configuration registers, and
// turns each accepted tile word into a bundle of result words.
// Depends on tmrle_pkg.
`timescale 1ns / 1ps

module tmrle_tracker import tmrle_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_fire,
  input  logic [WORD_W-1:0]     in_word,
  input  logic                  layer_end,
  output bundle_t               bundle
);

  localparam logic [IDX_W-1:0] ENTRIES = IDX_W'(TILEMAP_ENTRIES);

  logic [WORD_W-1:0]  dest_base;
  logic               append_terminator;

  logic [WORD_W-1:0]  run_value, run_value_next;
  logic [START_W-1:0] run_start, run_start_next;
  logic [LEN_W-1:0]   run_len, run_len_next;
  logic               run_open, run_open_next;

  logic [IDX_W-1:0]   idx;
  logic [IDX_W-1:0]   idx_inc;
  logic               extend;
  logic               close_old;
  logic               close_layer;
  logic [WORD_W-1:0]  old_dest, old_len, new_dest, new_len;
  logic [WORD_W-1:0]  upd_value;
  logic [START_W-1:0] upd_start;
  logic [LEN_W-1:0]   upd_length;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      dest_base         <= '0;
      append_terminator <= 1'b0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_DEST_BASE:   dest_base         <= cfg_data;
        REG_APPEND_TERM: append_terminator <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Run bookkeeping for the arriving word
  always_comb begin
    idx         = run_open ? (IDX_W'(run_start) + IDX_W'(run_len)) : '0;
    idx_inc     = idx + 14'd1;
    extend      = run_open && (in_word == run_value);
    close_old   = run_open && !extend;
    close_layer = layer_end || (idx_inc >= ENTRIES);

    if (extend) begin
      upd_value  = run_value;
      upd_start  = run_start;
      upd_length = run_len + 13'd1;
    end else begin
      upd_value  = in_word;
      upd_start  = idx[START_W-1:0];
      upd_length = 13'd1;
    end

    old_dest = dest_base + WORD_W'(run_start);
    old_len  = len_word(run_len);
    new_dest = dest_base + WORD_W'(upd_start);
    new_len  = len_word(upd_length);

    if (close_layer) begin
      run_value_next = '0;
      run_start_next = '0;
      run_len_next   = '0;
      run_open_next  = 1'b0;
    end else begin
      run_value_next = upd_value;
      run_start_next = upd_start;
      run_len_next   = upd_length;
      run_open_next  = 1'b1;
    end
  end

  // Bundle of results: closed run first, then the layer's last run and terminator
  always_comb begin
    bundle       = '0;
    bundle.term  = close_layer && append_terminator;
    if (close_old) begin
      bundle.words[0] = old_dest;
      bundle.words[1] = old_len;
      bundle.words[2] = run_value;
      bundle.words[3] = new_dest;
      bundle.words[4] = new_len;
      bundle.words[5] = upd_value;
      bundle.words[6] = TERM_BYTE;
      if (close_layer) begin
        bundle.cnt = append_terminator ? 3'd7 : 3'd6;
      end else begin
        bundle.cnt = 3'd3;
      end
    end else begin
      bundle.words[0] = new_dest;
      bundle.words[1] = new_len;
      bundle.words[2] = upd_value;
      bundle.words[3] = TERM_BYTE;
      if (close_layer) begin
        bundle.cnt = append_terminator ? 3'd4 : 3'd3;
      end else begin
        bundle.cnt = 3'd0;
      end
    end
    bundle.valid = in_fire && (bundle.cnt != '0);
  end

  // Run state
  always_ff @(posedge clk) begin
    if (rst) begin
      run_open  <= 1'b0;
      run_value <= '0;
      run_start <= '0;
      run_len   <= '0;
    end else if (in_fire) begin
      run_open  <= run_open_next;
      run_value <= run_value_next;
      run_start <= run_start_next;
      run_len   <= run_len_next;
    end
  end

endmodule

@@ rtl/tmrle_serializer.sv @@
// Result register and serializer: holds one bundle and sends its words
// one per cycle on the output stream while m_tready is high. Depends on tmrle_pkg.
`timescale 1ns / 1ps

module tmrle_serializer import tmrle_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  bundle_t           bundle_in,
  output logic              free,          // a new bundle may load this cycle
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [WORD_W-1:0] m_tdata,       // [15:0] out_word
  output logic              m_tuser,       // [0] terminator_byte
  output logic              m_tlast        // final_item
);

  bundle_t          held;
  logic             held_valid;
  logic [POS_W-1:0] pos;
  logic             take;
  logic             at_last;

  assign at_last  = (pos == (held.cnt - 3'd1));
  assign take     = held_valid && m_tready;
  assign free     = !held_valid || (take && at_last);

  // Output word selection
  assign m_tvalid = held_valid;
  assign m_tdata  = held.words[pos];
  assign m_tlast  = at_last;
  assign m_tuser  = at_last && held.term;

  // Control: bundle occupancy and word position
  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
      pos        <= '0;
    end else if (free && bundle_in.valid) begin
      held_valid <= 1'b1;
      pos        <= '0;
    end else if (take) begin
      if (at_last) begin
        held_valid <= 1'b0;
      end else begin
        pos <= pos + 3'd1;
      end
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (rst) begin
      held <= '0;
    end else if (free && bundle_in.valid) begin
      held <= bundle_in;
    end
  end

  // A held bundle is always one of the legal result counts
  a_cnt_legal: assert property (@(posedge clk) disable iff (rst)
    held_valid |-> (held.cnt == 3'd3 || held.cnt == 3'd4 ||
                    held.cnt == 3'd6 || held.cnt == 3'd7))
    else $error("illegal bundle count");

  // Terminator is only the final word and carries the terminator byte
  a_term_word: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser) |-> (m_tlast && m_tdata == TERM_BYTE))
    else $error("terminator misplaced");

  // Position never runs past the bundle
  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    held_valid |-> (pos < held.cnt))
    else $error("position past bundle");

  // Taking a non-final word keeps the bundle and advances one place
  a_advance: assert property (@(posedge clk) disable iff (rst)
    (take && !at_last) |=> (held_valid && pos == $past(pos) + 3'd1))
    else $error("serializer failed to advance");

endmodule

@@ rtl/tilemap_run_length_encoder.sv @@
// Top level of the tilemap run-length encoder: input stream, tracker,
// serializer and output stream. Depends on tmrle_pkg and both submodules.
// The first result word appears in the cycle after the word that closes a run.
// Throughput: a word is accepted every cycle while no result is pending; a
// word that closes runs holds input for its 3 to 7 words, one per ready cycle.
// Reset (rst, synchronous) clears the open run, the registers and the outputs.
`timescale 1ns / 1ps

module tilemap_run_length_encoder import tmrle_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  // Configuration write port
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  // Input stream
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [WORD_W-1:0]     s_tdata,   // [15:0] tile entry
  input  logic                  s_tlast,   // layer_end
  // Output stream
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [WORD_W-1:0]     m_tdata,   // [15:0] out_word
  output logic                  m_tuser,   // [0] terminator_byte
  output logic                  m_tlast    // final_item
);

  bundle_t bundle;
  logic    free;
  logic    in_fire;

  // A request is taken whenever the result register can load
  assign s_tready = free;
  assign in_fire  = s_tvalid && s_tready;

  tmrle_tracker u_tracker (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_fire   (in_fire),
    .in_word   (s_tdata),
    .layer_end (s_tlast),
    .bundle    (bundle)
  );

  tmrle_serializer u_serializer (
    .clk       (clk),
    .rst       (rst),
    .bundle_in (bundle),
    .free      (free),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
  );

endmodule
